>>> rtl/core/pps_pkg.sv
// Shared types and constants of the Phong point-light shader.
// Used by the modules under rtl/core other than pps_fifo; depends on nothing else.
package pps_pkg;

  localparam int unsigned NORMAL_W         = 32;
  localparam int unsigned DIR_W            = 16;
  localparam int unsigned SUMSQ_W          = 64;
  localparam int unsigned ROOT_W           = 32;
  localparam int unsigned SQRT_STEPS       = 32;
  localparam int unsigned COLOR_W          = 8;
  localparam int unsigned COEF_W           = 16;
  localparam int unsigned COEF_FRAC        = 15;
  localparam int unsigned CFG_W            = 48;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CHAN_MAX         = 255;
  localparam int unsigned MID_DEPTH        = 4;
  localparam int unsigned OUT_DEPTH        = 2;
  localparam int unsigned DEF_SPEC_EXP     = 8;
  localparam int unsigned DEF_FRACTION_BITS = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMBIENT_COLOR    = 3'd0,
    CFG_LIGHT_COLOR      = 3'd1,
    CFG_LIGHT_DIRECTION  = 3'd2,
    CFG_VIEW_DIRECTION   = 3'd3,
    CFG_AMBIENT_REFLECT  = 3'd4,
    CFG_DIFFUSE_REFLECT  = 3'd5,
    CFG_SPECULAR_REFLECT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] ambient_color;
    logic [23:0] light_color;
    logic [47:0] light_direction;
    logic [47:0] view_direction;
    logic [47:0] ambient_reflect;
    logic [47:0] diffuse_reflect;
    logic [47:0] specular_reflect;
  } cfg_t;

  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
  } shade_in_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               zero_normal;
  } shade_out_t;

  // Vector split into sign and magnitude, component 0 is x.
  typedef struct packed {
    logic [2:0]                 neg;
    logic [2:0][NORMAL_W-1:0]   amp;
    logic                       zero;
  } vec_abs_t;

  typedef struct packed {
    vec_abs_t              vec;
    logic [SUMSQ_W-1:0]    sumsq;
  } norm_req_t;

endpackage

>>> rtl/core/pps_fifo.sv
// Small register-based queue used between front and back and at the output.
// Depends on nothing; DEPTH must be a power of two.
module pps_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/pps_front.sv
// Front end: accepts normals, splits them into sign and magnitude and forms
// the sum of squares for the middle queue. Depends on pps_pkg.
module pps_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pps_pkg::shade_in_t    in_i,
  output logic                  full_o,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output pps_pkg::norm_req_t    q_data_o
);

  localparam int unsigned NW = pps_pkg::NORMAL_W;
  localparam int unsigned SW = pps_pkg::SUMSQ_W;

  logic                  f_en;
  logic                  f1_vld_q, f2_vld_q;
  logic [2:0][NW-1:0]    raw;
  logic [2:0][NW-1:0]    amp_d;
  logic [2:0]            neg_d;
  logic [2:0][NW-1:0]    f1_amp_q;
  logic [2:0]            f1_neg_q;
  logic [2:0][SW-1:0]    f2_sq_q;
  pps_pkg::vec_abs_t     f2_vec_q;

  assign raw[0] = in_i.normal_x;
  assign raw[1] = in_i.normal_y;
  assign raw[2] = in_i.normal_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = raw[i][NW-1];
      amp_d[i] = neg_d[i] ? (NW'(0) - raw[i]) : raw[i];
    end
  end

  // The front stage moves unless its last item cannot enter the queue.
  assign f_en   = !(f2_vld_q && q_full_i);
  assign full_o = !f_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (f_en) begin
      f1_vld_q <= push_i;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en) begin
      f1_amp_q      <= amp_d;
      f1_neg_q      <= neg_d;
      for (int i = 0; i < 3; i++) begin
        f2_sq_q[i] <= SW'(f1_amp_q[i]) * SW'(f1_amp_q[i]);
      end
      f2_vec_q.neg  <= f1_neg_q;
      f2_vec_q.amp  <= f1_amp_q;
      f2_vec_q.zero <= (f1_amp_q == '0);
    end
  end

  assign q_push_o       = f2_vld_q && !q_full_i;
  assign q_data_o.vec   = f2_vec_q;
  assign q_data_o.sumsq = f2_sq_q[0] + f2_sq_q[1] + f2_sq_q[2];

endmodule

>>> rtl/core/pps_norm.sv
// Pipelined vector normalizer: one square-root step per stage, then one
// quotient bit per stage for all three components. Depends on pps_pkg.
module pps_norm #(
  parameter int unsigned FRACTION_BITS = pps_pkg::DEF_FRACTION_BITS
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  pps_pkg::norm_req_t            req_i,
  output logic [2:0][FRACTION_BITS:0]   unit_o,
  output logic                          zero_o
);

  localparam int unsigned STEPS  = pps_pkg::SQRT_STEPS;
  localparam int unsigned SW     = pps_pkg::SUMSQ_W;
  localparam int unsigned RW     = pps_pkg::ROOT_W;
  localparam int unsigned QW     = FRACTION_BITS + 1;
  localparam int unsigned DSTEPS = FRACTION_BITS + 1;
  localparam int unsigned DW     = RW + FRACTION_BITS + 1;
  localparam logic [QW-1:0] QMAX = {1'b0, {FRACTION_BITS{1'b1}}};

  logic [SW-1:0]          sq_rem_q  [STEPS];
  logic [SW-1:0]          sq_root_q [STEPS];
  pps_pkg::vec_abs_t      sq_vec_q  [STEPS];

  logic [2:0][DW-1:0]     dv_rem_q  [DSTEPS];
  logic [2:0][QW-1:0]     dv_quo_q  [DSTEPS];
  logic [RW-1:0]          dv_mag_q  [DSTEPS];
  logic [2:0]             dv_neg_q  [DSTEPS];
  logic                   dv_zero_q [DSTEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (STEPS - 1 - k));
    logic [SW-1:0]     rem_in, root_in, trial;
    pps_pkg::vec_abs_t vec_in;
    if (k == 0) begin : g_first
      assign rem_in  = req_i.sumsq;
      assign root_in = '0;
      assign vec_in  = req_i.vec;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign vec_in  = sq_vec_q[k-1];
    end
    assign trial = root_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          sq_rem_q[k]  <= rem_in - trial;
          sq_root_q[k] <= (root_in >> 1) + BIT;
        end else begin
          sq_rem_q[k]  <= rem_in;
          sq_root_q[k] <= root_in >> 1;
        end
        sq_vec_q[k] <= vec_in;
      end
    end
  end

  // Each component is at most the root, so the quotient never exceeds 1.0.
  for (genvar j = 0; j < DSTEPS; j++) begin : g_div
    localparam int unsigned SH = FRACTION_BITS - j;
    logic [2:0][DW-1:0] rem_in;
    logic [2:0][QW-1:0] quo_in;
    logic [RW-1:0]      mag_in;
    logic [2:0]         neg_in;
    logic               zero_in;
    logic [DW-1:0]      dvs;
    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = DW'(sq_vec_q[STEPS-1].amp[i]) << FRACTION_BITS;
      end
      assign quo_in  = '0;
      assign mag_in  = sq_root_q[STEPS-1][RW-1:0];
      assign neg_in  = sq_vec_q[STEPS-1].neg;
      assign zero_in = sq_vec_q[STEPS-1].zero;
    end else begin : g_next
      assign rem_in  = dv_rem_q[j-1];
      assign quo_in  = dv_quo_q[j-1];
      assign mag_in  = dv_mag_q[j-1];
      assign neg_in  = dv_neg_q[j-1];
      assign zero_in = dv_zero_q[j-1];
    end
    assign dvs = DW'(mag_in) << SH;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dvs) begin
            dv_rem_q[j][i]     <= rem_in[i] - dvs;
            dv_quo_q[j][i]     <= quo_in[i] | (QW'(1) << SH);
          end else begin
            dv_rem_q[j][i]     <= rem_in[i];
            dv_quo_q[j][i]     <= quo_in[i];
          end
        end
        dv_mag_q[j]  <= mag_in;
        dv_neg_q[j]  <= neg_in;
        dv_zero_q[j] <= zero_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_q[DSTEPS-1]) begin
        unit_o[i] = '0;
      end else if (dv_neg_q[DSTEPS-1][i]) begin
        unit_o[i] = QW'(0) - dv_quo_q[DSTEPS-1][i];
      end else if (dv_quo_q[DSTEPS-1][i] > QMAX) begin
        unit_o[i] = QMAX;
      end else begin
        unit_o[i] = dv_quo_q[DSTEPS-1][i];
      end
    end
  end

  assign zero_o = dv_zero_q[DSTEPS-1];

endmodule

>>> rtl/core/pps_back.sv
// Back end: normalizes the item and the light, forms both cosines, the
// specular power and the per-channel sums. Depends on pps_pkg and pps_norm.
module pps_back #(
  parameter int unsigned SPECULAR_EXPONENT = pps_pkg::DEF_SPEC_EXP,
  parameter int unsigned FRACTION_BITS     = pps_pkg::DEF_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pps_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  input  pps_pkg::norm_req_t    in_data_i,
  output logic                  in_pop_o,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output pps_pkg::shade_out_t   out_data_o
);

  localparam int unsigned FB   = FRACTION_BITS;
  localparam int unsigned E    = SPECULAR_EXPONENT;
  localparam int unsigned DIRW = pps_pkg::DIR_W;
  localparam int unsigned CF   = pps_pkg::COEF_FRAC;
  localparam int unsigned NW   = FB + 1;
  localparam int unsigned CW   = FB + 1;
  localparam int unsigned PW   = 2 * NW;
  localparam int unsigned DSW  = PW + 2;
  localparam int unsigned MW   = NW + CW + 2;
  localparam int unsigned RW   = FB + 3;
  localparam int unsigned VW   = FB + 1;
  localparam int unsigned XW   = DIRW + FB + 1;
  localparam int unsigned RVW  = RW + VW;
  localparam int unsigned RVSW = RVW + 2;
  localparam int unsigned LKW  = pps_pkg::COLOR_W + pps_pkg::COEF_W;
  localparam int unsigned TW   = LKW + CW - CF - FB;
  localparam int unsigned AMW  = LKW - CF;
  localparam int unsigned SUMW = TW + 2;
  localparam int unsigned LAT  = pps_pkg::SQRT_STEPS + FB + 1 + 6 + (E - 1) + 2;
  localparam logic [CW-1:0] ONE  = {1'b1, {FB{1'b0}}};
  localparam logic [MW-1:0] MBIAS = {{(MW-FB){1'b0}}, {FB{1'b1}}};
  localparam logic [XW-1:0] VBIAS = XW'((1 << CF) - 1);

  logic              en;
  logic [LAT-1:0]    vld_q;

  // Values that follow from configuration alone; they settle long before
  // any item reaches the stage that uses them.
  pps_pkg::norm_req_t   lreq_q;
  logic [2:0][VW-1:0]   view_q;
  logic [2:0][LKW-1:0]  lkd_q, lks_q;
  logic [2:0][AMW-1:0]  amb_q;

  always_ff @(posedge clk_i) begin : cfg_derived
    logic signed [DIRW-1:0] lx;
    logic [DIRW:0]          la;
    logic signed [XW-1:0]   vx, vb, vt;
    logic [pps_pkg::SUMSQ_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      lx = cfg_i.light_direction[DIRW*(2-i) +: DIRW];
      la = lx[DIRW-1] ? ((DIRW+1)'(0) - {lx[DIRW-1], lx}) : {1'b0, lx};
      lreq_q.vec.neg[i] <= lx[DIRW-1];
      lreq_q.vec.amp[i] <= pps_pkg::NORMAL_W'(la);
      acc = acc + pps_pkg::SUMSQ_W'(la) * pps_pkg::SUMSQ_W'(la);
      vx = XW'($signed(cfg_i.view_direction[DIRW*(2-i) +: DIRW])) <<< FB;
      vb = vx + (vx[XW-1] ? VBIAS : '0);
      vt = vb >>> CF;
      view_q[i] <= vt[VW-1:0];
      lkd_q[i] <= LKW'(cfg_i.light_color[8*(2-i) +: 8]) *
                  LKW'(cfg_i.diffuse_reflect[16*(2-i) +: 16]);
      lks_q[i] <= LKW'(cfg_i.light_color[8*(2-i) +: 8]) *
                  LKW'(cfg_i.specular_reflect[16*(2-i) +: 16]);
      amb_q[i] <= AMW'((LKW'(cfg_i.ambient_color[8*(2-i) +: 8]) *
                        LKW'(cfg_i.ambient_reflect[16*(2-i) +: 16])) >> CF);
    end
    lreq_q.sumsq    <= acc;
    lreq_q.vec.zero <= (cfg_i.light_direction == '0);
  end

  // The item pipeline advances together unless the finished item is blocked.
  assign en         = !(vld_q[LAT-1] && out_full_i);
  assign in_pop_o   = in_valid_i && en;
  assign out_push_o = vld_q[LAT-1] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic [2:0][NW-1:0] nn, ll;
  logic               nzero;

  pps_norm #(.FRACTION_BITS(FB)) u_norm_item (
    .clk_i  (clk_i),
    .en_i   (en),
    .req_i  (in_data_i),
    .unit_o (nn),
    .zero_o (nzero)
  );

  pps_norm #(.FRACTION_BITS(FB)) u_norm_light (
    .clk_i  (clk_i),
    .en_i   (1'b1),
    .req_i  (lreq_q),
    .unit_o (ll),
    .zero_o ()
  );

  // Stage 1: component products of N and L.
  logic [2:0][PW-1:0] s1_nl_q;
  logic [2:0][NW-1:0] s1_n_q, s1_l_q;
  logic               s1_z_q;
  // Stage 2: diffuse cosine.
  logic [CW-1:0]      s2_cd_q;
  logic [2:0][NW-1:0] s2_n_q, s2_l_q;
  logic               s2_z_q;
  // Stage 3: 2 N cos.
  logic [2:0][MW-1:0] s3_m_q;
  logic [2:0][NW-1:0] s3_l_q;
  logic [CW-1:0]      s3_cd_q;
  logic               s3_z_q;
  // Stage 4: reflected vector.
  logic [2:0][RW-1:0] s4_r_q;
  logic [CW-1:0]      s4_cd_q;
  logic               s4_z_q;
  // Stage 5: products of R and V.
  logic [2:0][RVW-1:0] s5_rv_q;
  logic [CW-1:0]       s5_cd_q;
  logic                s5_z_q;
  // Power chain, entry 0 holds the specular cosine itself.
  logic [CW-1:0]      pw_p_q  [E];
  logic [CW-1:0]      pw_s_q  [E];
  logic [CW-1:0]      pw_cd_q [E];
  logic               pw_z_q  [E];
  // Stage 7: diffuse and specular terms per channel.
  logic [2:0][TW-1:0] s7_dif_q, s7_spc_q;
  logic               s7_z_q;
  pps_pkg::shade_out_t s8_out_q;

  logic signed [DSW-1:0]  dot1;
  logic [DSW-FB-1:0]      ctr1;
  logic [CW-1:0]          cd_d;
  logic signed [RVSW-1:0] dot2;
  logic [RVSW-FB-1:0]     ctr2;
  logic [CW-1:0]          cs_d;

  always_comb begin
    dot1 = DSW'($signed(s1_nl_q[0])) + DSW'($signed(s1_nl_q[1])) +
           DSW'($signed(s1_nl_q[2]));
    ctr1 = dot1[DSW-1:FB];
    if (dot1[DSW-1] || dot1 == '0) begin
      cd_d = '0;
    end else if (ctr1 > (DSW-FB)'(ONE)) begin
      cd_d = ONE;
    end else begin
      cd_d = ctr1[CW-1:0];
    end
    dot2 = RVSW'($signed(s5_rv_q[0])) + RVSW'($signed(s5_rv_q[1])) +
           RVSW'($signed(s5_rv_q[2]));
    ctr2 = dot2[RVSW-1:FB];
    if (dot2[RVSW-1] || dot2 == '0) begin
      cs_d = '0;
    end else if (ctr2 > (RVSW-FB)'(ONE)) begin
      cs_d = ONE;
    end else begin
      cs_d = ctr2[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin : front_stages
    logic signed [MW-1:0] mb, mt;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_nl_q[i] <= $signed(nn[i]) * $signed(ll[i]);
        mb = $signed(s3_m_q[i]) + (s3_m_q[i][MW-1] ? MBIAS : '0);
        mt = mb >>> FB;
        s4_r_q[i]  <= $signed(mt[RW-1:0]) - RW'($signed(s3_l_q[i]));
        s3_m_q[i]  <= $signed(s2_n_q[i]) * $signed({1'b0, s2_cd_q, 1'b0});
        s5_rv_q[i] <= $signed(s4_r_q[i]) * $signed(view_q[i]);
      end
      s1_n_q  <= nn;
      s1_l_q  <= ll;
      s1_z_q  <= nzero;
      s2_cd_q <= cd_d;
      s2_n_q  <= s1_n_q;
      s2_l_q  <= s1_l_q;
      s2_z_q  <= s1_z_q;
      s3_l_q  <= s2_l_q;
      s3_cd_q <= s2_cd_q;
      s3_z_q  <= s2_z_q;
      s4_cd_q <= s3_cd_q;
      s4_z_q  <= s3_z_q;
      s5_cd_q <= s4_cd_q;
      s5_z_q  <= s4_z_q;
      pw_p_q[0]  <= cs_d;
      pw_s_q[0]  <= cs_d;
      pw_cd_q[0] <= s5_cd_q;
      pw_z_q[0]  <= s5_z_q;
    end
  end

  for (genvar k = 1; k < E; k++) begin : g_pow
    logic [2*CW-1:0] prod;
    assign prod = (2*CW)'(pw_p_q[k-1]) * (2*CW)'(pw_s_q[k-1]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        pw_p_q[k]  <= prod[FB+CW-1:FB];
        pw_s_q[k]  <= pw_s_q[k-1];
        pw_cd_q[k] <= pw_cd_q[k-1];
        pw_z_q[k]  <= pw_z_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin : back_stages
    logic [LKW+CW-1:0] dprod, sprod;
    logic [SUMW-1:0]   sum;
    logic [2:0][pps_pkg::COLOR_W-1:0] chan;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dprod = (LKW+CW)'(lkd_q[i]) * (LKW+CW)'(pw_cd_q[E-1]);
        sprod = (LKW+CW)'(lks_q[i]) * (LKW+CW)'(pw_p_q[E-1]);
        s7_dif_q[i] <= dprod[LKW+CW-1:CF+FB];
        s7_spc_q[i] <= sprod[LKW+CW-1:CF+FB];
        // A zero-length normal gets the ambient term alone.
        sum = SUMW'(amb_q[i]);
        if (!s7_z_q) begin
          sum = sum + SUMW'(s7_dif_q[i]) + SUMW'(s7_spc_q[i]);
        end
        chan[i] = (sum > SUMW'(pps_pkg::CHAN_MAX)) ?
                  pps_pkg::COLOR_W'(pps_pkg::CHAN_MAX) : sum[pps_pkg::COLOR_W-1:0];
      end
      s7_z_q               <= pw_z_q[E-1];
      s8_out_q.red         <= chan[0];
      s8_out_q.green       <= chan[1];
      s8_out_q.blue        <= chan[2];
      s8_out_q.zero_normal <= s7_z_q;
    end
  end

  assign out_data_o = s8_out_q;

endmodule

>>> rtl/core/phong_point_light_shader.sv
// Top level of the Phong point-light shader: configuration registers, the
// front end, the middle queue, the back end and the result queue.
// Depends on pps_pkg, pps_fifo, pps_front and pps_back.
//
// Usage:
//   Normals enter through push/full and in_i; an item is taken at a clock
//   edge with push high and full low. Results leave through empty/pop and
//   out_o; the oldest result sits on out_o while empty is low and is taken
//   at an edge with pop high. One result follows every normal, in order.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   no item is in flight; indexes past the last register are ignored.
//   Throughput is one normal per cycle while full is low. The delay from
//   push to empty falling is set by the 32-step square root, the
//   one-bit-per-stage divider and the multiply chain of the specular power.
//   When pop is held low the back end stops once its last stage holds a
//   result and the result queue is full; the front end then fills the
//   middle queue and raises full. Nothing is dropped.
//   Reset clears all queues and valid bits and loads the register reset
//   values; the view vector comes up as +z.
module phong_point_light_shader #(
  parameter int unsigned SPECULAR_EXPONENT = pps_pkg::DEF_SPEC_EXP,
  parameter int unsigned FRACTION_BITS     = pps_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  pps_pkg::shade_in_t             in_i,
  input  logic                           pop,
  output logic                           empty,
  output pps_pkg::shade_out_t            out_o,
  input  logic                           cfg_we_i,
  input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pps_pkg::CFG_W-1:0]      cfg_wdata_i
);

  pps_pkg::cfg_t      cfg_q, cfg_d;
  pps_pkg::norm_req_t mid_wdata, mid_rdata;
  logic               mid_push, mid_full, mid_empty, mid_pop;
  logic               out_push, out_full;
  pps_pkg::shade_out_t back_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pps_pkg::cfg_idx_e'(cfg_idx_i))
        pps_pkg::CFG_AMBIENT_COLOR:    cfg_d.ambient_color    = cfg_wdata_i[23:0];
        pps_pkg::CFG_LIGHT_COLOR:      cfg_d.light_color      = cfg_wdata_i[23:0];
        pps_pkg::CFG_LIGHT_DIRECTION:  cfg_d.light_direction  = cfg_wdata_i;
        pps_pkg::CFG_VIEW_DIRECTION:   cfg_d.view_direction   = cfg_wdata_i;
        pps_pkg::CFG_AMBIENT_REFLECT:  cfg_d.ambient_reflect  = cfg_wdata_i;
        pps_pkg::CFG_DIFFUSE_REFLECT:  cfg_d.diffuse_reflect  = cfg_wdata_i;
        pps_pkg::CFG_SPECULAR_REFLECT: cfg_d.specular_reflect = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{view_direction: 48'd32767, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .in_i     (in_i),
    .full_o   (full),
    .q_full_i (mid_full),
    .q_push_o (mid_push),
    .q_data_o (mid_wdata)
  );

  pps_fifo #(
    .WIDTH ($bits(pps_pkg::norm_req_t)),
    .DEPTH (pps_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_rdata)
  );

  pps_back #(
    .SPECULAR_EXPONENT (SPECULAR_EXPONENT),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (!mid_empty),
    .in_data_i  (mid_rdata),
    .in_pop_o   (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_data_o (back_data)
  );

  pps_fifo #(
    .WIDTH ($bits(pps_pkg::shade_out_t)),
    .DEPTH (pps_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_o)
  );

endmodule

>>> tb/pps_checker.sv
// Checker for the Phong point-light shader: mirrors the configuration writes,
// predicts one shaded color per accepted normal and compares it with the output.
// Depends on pps_pkg only.
`timescale 1ns / 100ps

module pps_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  pps_pkg::shade_in_t             in_i,
  input  logic                           pop,
  input  logic                           empty,
  input  pps_pkg::shade_out_t            out_o,
  input  logic                           cfg_we_i,
  input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pps_pkg::CFG_W-1:0]      cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             zero_seen_o
);

  localparam int FB = 15;
  localparam int SPEC_EXP = 8;
  localparam longint ONE = longint'(1) << FB;

  pps_pkg::cfg_t shade_cfg;
  pps_pkg::shade_out_t color_q[$];

  function automatic longint unsigned root64(input longint unsigned val);
    longint unsigned r, b, v;
    v = val;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scales a vector to unit length; returns 1 for the all-zero vector.
  function automatic bit unit_vec(input longint x, input longint y, input longint z,
                                  output longint ox, output longint oy, output longint oz);
    longint unsigned ax, ay, az, sum, mag;
    longint q[3];
    longint s[3];
    s[0] = x; s[1] = y; s[2] = z;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    sum = ax * ax + ay * ay + az * az;
    if (sum == 0) begin
      ox = 0; oy = 0; oz = 0;
      return 1'b1;
    end
    mag = root64(sum);
    q[0] = longint'((ax << FB) / mag);
    q[1] = longint'((ay << FB) / mag);
    q[2] = longint'((az << FB) / mag);
    for (int i = 0; i < 3; i++) begin
      if (s[i] < 0) q[i] = -q[i];
      else if (q[i] > ONE - 1) q[i] = ONE - 1;
    end
    ox = q[0]; oy = q[1]; oz = q[2];
    return 1'b0;
  endfunction

  function automatic longint cos_of(input longint ax, input longint ay, input longint az,
                                    input longint bx, input longint by, input longint bz);
    longint d;
    d = ax * bx + ay * by + az * bz;
    if (d <= 0) return 0;
    d = d >>> FB;
    return d > ONE ? ONE : d;
  endfunction

  function automatic pps_pkg::shade_out_t shade_predict(input pps_pkg::shade_in_t item,
                                                        input pps_pkg::cfg_t c);
    pps_pkg::shade_out_t res;
    longint n[3], l[3], v[3], r[3];
    longint cd, s, p;
    longint unsigned lc, sum;
    bit zero;
    cd = 0;
    p = 0;
    zero = unit_vec(longint'(item.normal_x), longint'(item.normal_y),
                    longint'(item.normal_z), n[0], n[1], n[2]);
    void'(unit_vec(longint'($signed(c.light_direction[47:32])),
                   longint'($signed(c.light_direction[31:16])),
                   longint'($signed(c.light_direction[15:0])), l[0], l[1], l[2]));
    v[0] = (longint'($signed(c.view_direction[47:32])) * ONE) / 32768;
    v[1] = (longint'($signed(c.view_direction[31:16])) * ONE) / 32768;
    v[2] = (longint'($signed(c.view_direction[15:0])) * ONE) / 32768;
    if (!zero) begin
      cd = cos_of(n[0], n[1], n[2], l[0], l[1], l[2]);
      for (int i = 0; i < 3; i++) r[i] = (2 * n[i] * cd) / ONE - l[i];
      s = cos_of(r[0], r[1], r[2], v[0], v[1], v[2]);
      p = s;
      for (int i = 1; i < SPEC_EXP; i++) p = (p * s) >>> FB;
    end
    for (int ch = 0; ch < 3; ch++) begin
      lc = (c.light_color >> (16 - 8 * ch)) & 8'hFF;
      sum = (((c.ambient_color >> (16 - 8 * ch)) & 8'hFF) *
             ((c.ambient_reflect >> (32 - 16 * ch)) & 16'hFFFF)) >> 15;
      if (!zero) begin
        sum += (lc * ((c.diffuse_reflect >> (32 - 16 * ch)) & 16'hFFFF) * cd) >> (15 + FB);
        sum += (lc * ((c.specular_reflect >> (32 - 16 * ch)) & 16'hFFFF) * p) >> (15 + FB);
      end
      if (sum > pps_pkg::CHAN_MAX) sum = pps_pkg::CHAN_MAX;
      case (ch)
        0: res.red = sum[7:0];
        1: res.green = sum[7:0];
        default: res.blue = sum[7:0];
      endcase
    end
    res.zero_normal = zero;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pps_pkg::shade_out_t want;
    if (!rst_ni) begin
      shade_cfg <= '{view_direction: 48'd32767, default: '0};
      color_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      zero_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (pps_pkg::cfg_idx_e'(cfg_idx_i))
          pps_pkg::CFG_AMBIENT_COLOR:    shade_cfg.ambient_color <= cfg_wdata_i[23:0];
          pps_pkg::CFG_LIGHT_COLOR:      shade_cfg.light_color <= cfg_wdata_i[23:0];
          pps_pkg::CFG_LIGHT_DIRECTION:  shade_cfg.light_direction <= cfg_wdata_i;
          pps_pkg::CFG_VIEW_DIRECTION:   shade_cfg.view_direction <= cfg_wdata_i;
          pps_pkg::CFG_AMBIENT_REFLECT:  shade_cfg.ambient_reflect <= cfg_wdata_i;
          pps_pkg::CFG_DIFFUSE_REFLECT:  shade_cfg.diffuse_reflect <= cfg_wdata_i;
          pps_pkg::CFG_SPECULAR_REFLECT: shade_cfg.specular_reflect <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (color_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = color_q.pop_front();
          checked_o <= checked_o + 1;
          if (want.zero_normal) zero_seen_o <= zero_seen_o + 1;
          if (out_o.red !== want.red || out_o.green !== want.green ||
              out_o.blue !== want.blue || out_o.zero_normal !== want.zero_normal) begin
            $display("%0t: color mismatch, expected r=%0d g=%0d b=%0d z=%0b,",
                     $time, want.red, want.green, want.blue, want.zero_normal);
            $display("%0t:   actual r=%0d g=%0d b=%0d z=%0b",
                     $time, out_o.red, out_o.green, out_o.blue, out_o.zero_normal);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (push && !full) color_q.push_back(shade_predict(in_i, shade_cfg));
      pending_o <= color_q.size();
    end
  end

endmodule

>>> tb/tb_phong_point_light_shader.sv
// Testbench top of the Phong point-light shader: clock, reset, configuration
// phases and normal stimulus with random idling on both queues.
// Depends on pps_pkg, phong_point_light_shader and pps_checker.
`timescale 1ns / 100ps

module tb_phong_point_light_shader;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT = 100;

  logic clk_i, rst_ni;
  logic push, full, pop, empty;
  pps_pkg::shade_in_t in_i;
  pps_pkg::shade_out_t out_o;
  logic cfg_we_i;
  logic [pps_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pps_pkg::CFG_W-1:0] cfg_wdata_i;
  int fail_count, pending, checked, zero_seen;
  int cycles = 0;
  bit calm;
  bit squeeze;
  int normals_sent;

  phong_point_light_shader u_top (
    .clk_i, .rst_ni, .push, .full, .in_i, .pop, .empty, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  pps_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .in_i, .pop, .empty, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .zero_seen_o(zero_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    bit held;
    held = 1'b0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze && !held) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk_i);
        held = 1'b1;
      end
      pop <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  task automatic write_reg(input pps_pkg::cfg_idx_e idx,
                           input logic [pps_pkg::CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cfg(input logic [23:0] amb, input logic [23:0] lcol,
                          input logic [47:0] ldir, input logic [47:0] vdir,
                          input logic [47:0] ka, input logic [47:0] kd,
                          input logic [47:0] ks);
    write_reg(pps_pkg::CFG_AMBIENT_COLOR, {24'd0, amb});
    write_reg(pps_pkg::CFG_LIGHT_COLOR, {24'd0, lcol});
    write_reg(pps_pkg::CFG_LIGHT_DIRECTION, ldir);
    write_reg(pps_pkg::CFG_VIEW_DIRECTION, vdir);
    write_reg(pps_pkg::CFG_AMBIENT_REFLECT, ka);
    write_reg(pps_pkg::CFG_DIFFUSE_REFLECT, kd);
    write_reg(pps_pkg::CFG_SPECULAR_REFLECT, ks);
  endtask

  task automatic send_normal(input int x, input int y, input int z);
    while (!calm && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= '{normal_x: x, normal_y: y, normal_z: z};
    do @(posedge clk_i); while (full);
    normals_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic int rand_comp(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(200) - 100;
      2: return $urandom_range(65535) - 32768;
      default: return 0;
    endcase
  endfunction

  function automatic logic [47:0] rand_dir();
    return {16'($urandom()), 16'($urandom()), 16'($urandom())};
  endfunction

  initial begin
    int mode;
    int pick;
    rst_ni = 1'b0;
    push = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    calm = 1'b0;
    squeeze = 1'b0;
    normals_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: only the zero-normal flag can be set.
    send_normal(0, 0, 0);
    send_normal(5, -7, 9);
    drain();

    load_cfg(24'h807F40, 24'hFFFFFF, {16'd0, 16'd0, 16'h7FFF}, 48'd32767,
             {3{16'h4000}}, {3{16'h7FFF}}, {3{16'hFFFF}});
    send_normal(0, 0, 0);
    send_normal(0, 0, 32'h7FFFFFFF);
    send_normal(0, 0, 32'h80000000);
    send_normal(32'h7FFFFFFF, 0, 0);
    send_normal(32'h80000000, 0, 0);
    send_normal(0, 32'h7FFFFFFF, 0);
    send_normal(0, 32'h80000000, 0);
    send_normal(32'h80000000, 32'h80000000, 32'h80000000);
    send_normal(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_normal(1, 1, 1);
    send_normal(-1, 2, 5);
    send_normal(0, 0, 1);
    send_normal(3, 0, 4);
    drain();

    // Zero light direction and an unnormalized view vector.
    load_cfg(24'hFFFFFF, 24'hFFFFFF, 48'd0, {16'h7FFF, 16'h7FFF, 16'h7FFF},
             {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}});
    send_normal(0, 0, 1);
    send_normal(0, 0, 0);
    send_normal(-4, 9, 2);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_cfg(24'hFFFFFF, 24'hFFFFFF, rand_dir(), rand_dir(),
                    {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}});
        1: load_cfg(24'h0, 24'h0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0);
        2: load_cfg(24'($urandom()), 24'hFFFFFF, {16'd0, 16'd0, 16'h7FFF}, 48'd32767,
                    {3{16'h1000}}, {3{16'h6000}}, {3{16'h8000}});
        default: load_cfg(24'($urandom()), 24'($urandom()),
                          ($urandom_range(9) == 0) ? 48'd0 : rand_dir(),
                          ($urandom_range(1) == 0) ? 48'd32767 : rand_dir(),
                          rand_dir(), rand_dir(), rand_dir());
      endcase
      calm = (ph == 3);
      squeeze = (ph == 2);
      for (int k = 0; k < 255; k++) begin
        mode = $urandom_range(3);
        pick = $urandom_range(19);
        if (pick == 0) send_normal(0, 0, 0);
        else if (pick == 1) send_normal(0, 0, rand_comp(mode));
        else send_normal(rand_comp(mode), rand_comp($urandom_range(2)), rand_comp(mode));
      end
      drain();
    end
    calm = 1'b0;

    $display("Sent %0d normals over nine configuration settings; %0d colors checked,",
             normals_sent, checked);
    $display("%0d of them for zero-length normals, with one long output stall.", zero_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
